### hw/rtl/mdru_pkg.sv
`timescale 1ns / 1ps

package mdru_pkg;

  // Access direction
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Write map
  localparam logic [15:0] ADDR_MULTIPLICAND = 16'h4202;
  localparam logic [15:0] ADDR_MULTIPLIER   = 16'h4203;
  localparam logic [15:0] ADDR_DIVIDEND_LO  = 16'h4204;
  localparam logic [15:0] ADDR_DIVIDEND_HI  = 16'h4205;
  localparam logic [15:0] ADDR_DIVISOR      = 16'h4206;

  // Read map
  localparam logic [15:0] ADDR_QUOT_LO   = 16'h4214;
  localparam logic [15:0] ADDR_QUOT_HI   = 16'h4215;
  localparam logic [15:0] ADDR_PRDREM_LO = 16'h4216;
  localparam logic [15:0] ADDR_PRDREM_HI = 16'h4217;

  localparam logic [15:0] DIV_BY_ZERO_QUOT = 16'hFFFF;

endpackage

### hw/rtl/mul_div_register_unit.sv
`timescale 1ns / 1ps

// Channel   Valid / ready                Payload
// --------  ---------------------------  ----------------------------
// request   in_valid_i / in_ready_o      func_i, addr_i, wdata_i
// response  out_valid_o / out_ready_i    rdata_o, hit_o
//
// Every request gives one response, loaded into an output register when the
// request is taken. Reads and plain writes finish when taken. A multiplier
// write runs 8 shift-add steps and a nonzero divisor write 16 restoring
// divide steps on one shared 17-bit adder; the request port stays low for
// those cycles. A zero divisor finishes at once. Reset clears all registers.
// A stalled response holds and blocks the next request.

module mul_div_register_unit
  import mdru_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  rdata_o,
  output logic        hit_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] shf_q, shf_d;
  logic [7:0]  opnd_q, opnd_d;
  logic [7:0]  mcand_q, mcand_d;
  logic [7:0]  dvd_lo_q, dvd_lo_d;
  logic [7:0]  dvd_hi_q, dvd_hi_d;
  logic [15:0] quot_q, quot_d;
  logic [15:0] prdrem_q, prdrem_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  rdata_q, rdata_d;
  logic        hit_q, hit_d;

  logic        accept;
  logic [16:0] alu_a, alu_b;
  logic        alu_sub;
  logic [17:0] alu_sum;
  logic [8:0]  rem_sh;
  logic        quot_bit;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign rdata_o     = rdata_q;
  assign hit_o       = hit_q;

  // Shared adder: multiply adds the multiplicand, divide subtracts the divisor
  assign rem_sh = {acc_q[7:0], shf_q[15]};
  always_comb begin
    if (state_q == ST_DIV) begin
      alu_a   = {8'd0, rem_sh};
      alu_b   = {9'd0, opnd_q};
      alu_sub = 1'b1;
    end else begin
      alu_a   = {1'b0, acc_q[14:0], 1'b0};
      alu_b   = shf_q[7] ? {9'd0, opnd_q} : 17'd0;
      alu_sub = 1'b0;
    end
  end
  assign alu_sum  = {1'b0, alu_a} + {1'b0, alu_b ^ {17{alu_sub}}} + {17'd0, alu_sub};
  assign quot_bit = alu_sum[17];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    shf_d       = shf_q;
    opnd_d      = opnd_q;
    mcand_d     = mcand_q;
    dvd_lo_d    = dvd_lo_q;
    dvd_hi_d    = dvd_hi_q;
    quot_d      = quot_q;
    prdrem_d    = prdrem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rdata_d     = rdata_q;
    hit_d       = hit_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          rdata_d     = 8'd0;
          hit_d       = 1'b0;
          if (func_i == FUNC_WRITE) begin
            hit_d = addr_i inside {[ADDR_MULTIPLICAND:ADDR_DIVISOR]};
            case (addr_i)
              ADDR_MULTIPLICAND: mcand_d = wdata_i;
              ADDR_MULTIPLIER: begin
                acc_d   = 16'd0;
                shf_d   = {8'd0, wdata_i};
                opnd_d  = mcand_q;
                cnt_d   = 4'd7;
                state_d = ST_MUL;
              end
              ADDR_DIVIDEND_LO: dvd_lo_d = wdata_i;
              ADDR_DIVIDEND_HI: dvd_hi_d = wdata_i;
              ADDR_DIVISOR: begin
                if (wdata_i == 8'd0) begin
                  quot_d   = DIV_BY_ZERO_QUOT;
                  prdrem_d = {dvd_hi_q, dvd_lo_q};
                end else begin
                  acc_d   = 16'd0;
                  shf_d   = {dvd_hi_q, dvd_lo_q};
                  opnd_d  = wdata_i;
                  cnt_d   = 4'd15;
                  state_d = ST_DIV;
                end
              end
              default: ;
            endcase
          end else begin
            hit_d = addr_i inside {[ADDR_QUOT_LO:ADDR_PRDREM_HI]};
            case (addr_i)
              ADDR_QUOT_LO:   rdata_d = quot_q[7:0];
              ADDR_QUOT_HI:   rdata_d = quot_q[15:8];
              ADDR_PRDREM_LO: rdata_d = prdrem_q[7:0];
              ADDR_PRDREM_HI: rdata_d = prdrem_q[15:8];
              default:        rdata_d = 8'd0;
            endcase
          end
        end
      end
      ST_MUL: begin
        acc_d = alu_sum[15:0];
        shf_d = {shf_q[14:0], 1'b0};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          prdrem_d = alu_sum[15:0];
          state_d  = ST_IDLE;
        end
      end
      ST_DIV: begin
        // Keep the trial remainder only when the subtract does not borrow
        acc_d = quot_bit ? {7'd0, alu_sum[8:0]} : {7'd0, rem_sh};
        shf_d = {shf_q[14:0], quot_bit};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          quot_d   = {shf_q[14:0], quot_bit};
          prdrem_d = quot_bit ? {8'd0, alu_sum[7:0]} : {8'd0, rem_sh[7:0]};
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 4'd0;
      acc_q       <= 16'd0;
      shf_q       <= 16'd0;
      opnd_q      <= 8'd0;
      mcand_q     <= 8'd0;
      dvd_lo_q    <= 8'd0;
      dvd_hi_q    <= 8'd0;
      quot_q      <= 16'd0;
      prdrem_q    <= 16'd0;
      out_valid_q <= 1'b0;
      rdata_q     <= 8'd0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      shf_q       <= shf_d;
      opnd_q      <= opnd_d;
      mcand_q     <= mcand_d;
      dvd_lo_q    <= dvd_lo_d;
      dvd_hi_q    <= dvd_hi_d;
      quot_q      <= quot_d;
      prdrem_q    <= prdrem_d;
      out_valid_q <= out_valid_d;
      rdata_q     <= rdata_d;
      hit_q       <= hit_d;
    end
  end

endmodule

### hw/rtl/mdru_checker.sv
`timescale 1ns / 1ps

module mdru_checker
  import mdru_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        func_i,
  input logic [15:0] addr_i,
  input logic [7:0]  wdata_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  rdata_o,
  input logic        hit_o
);

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  // A write request responds next cycle with zero data
  a_write_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i == FUNC_WRITE |=> out_valid_o && rdata_o == 8'd0)
    else $error("write response not zero or missing");

  // A read outside the read map misses and returns zero
  a_read_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i == FUNC_READ && addr_i != ADDR_QUOT_LO && addr_i != ADDR_QUOT_HI
    && addr_i != ADDR_PRDREM_LO && addr_i != ADDR_PRDREM_HI
    |=> !hit_o && rdata_o == 8'd0)
    else $error("undecoded read hit or returned data");

  // Starting a multiply or a nonzero divide holds off the next request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i == FUNC_WRITE
    && (addr_i == ADDR_MULTIPLIER || (addr_i == ADDR_DIVISOR && wdata_i != 8'd0))
    |=> !in_ready_o)
    else $error("request taken while arithmetic runs");

  // A write to the multiplicand or either dividend register hits
  a_write_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i == FUNC_WRITE && (addr_i == ADDR_MULTIPLICAND
    || addr_i == ADDR_DIVIDEND_LO || addr_i == ADDR_DIVIDEND_HI) |=> hit_o)
    else $error("mapped write did not hit");

  // A stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rdata_o) && $stable(hit_o))
    else $error("stalled response changed");

endmodule

bind mul_div_register_unit mdru_checker u_mdru_checker (.*);
